FILE: rtl/ils_pkg.sv
// Shared types and constants of the indexed list store.
package ils_pkg;

   // Store geometry.
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 7;
   localparam int DATA_W   = 32;

   // Action codes carried by a request beat.
   typedef enum logic [2:0] {
      ACT_READ       = 3'd0,
      ACT_INS_HEAD   = 3'd1,
      ACT_APPEND     = 3'd2,
      ACT_INS_POS    = 3'd3,
      ACT_DELETE     = 3'd4
   } action_type;

   // Status codes carried by a response beat.
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Work that an accepted beat turns into, once checked against the length.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_READ,
      OP_INSERT,
      OP_DELETE
   } op_kind_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_READ_WAIT,
      S_RESPOND
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic mem_read;
      logic shift_write;
      logic place_write;
      logic len_inc;
      logic len_dec;
      logic capture_read;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_kind_type kind;
      logic        shift_more;
   } dp_status_type;

endpackage

FILE: rtl/ils_req_if.sv
// Request channel of the indexed list store.
interface ils_req_if;
   import ils_pkg::*;

   logic                valid;
   logic                ready;
   logic [2:0]          action;
   logic [LEN_W-1:0]    position;
   logic signed [31:0]  value;

   modport source (output valid, output action, output position, output value,
                   input ready);
   modport sink   (input valid, input action, input position, input value,
                   output ready);
endinterface

FILE: rtl/ils_rsp_if.sv
// Response channel of the indexed list store.
interface ils_rsp_if;
   import ils_pkg::*;

   logic                valid;
   logic                ready;
   logic signed [31:0]  read_value;
   logic [1:0]          status;
   logic [LEN_W-1:0]    list_length;

   modport source (output valid, output read_value, output status,
                   output list_length, input ready);
   modport sink   (input valid, input read_value, input status,
                   input list_length, output ready);
endinterface

FILE: rtl/ils_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ils_ctrl.sv
// Controller state machine of the indexed list store.
module ils_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ils_pkg::dp_status_type dp_status,
   output ils_pkg::ctrl_cmd_type  cmd
);
   import ils_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (dp_status.kind) inside
               OP_READ:   state_in = S_READ_WAIT;
               OP_INSERT,
               OP_DELETE: state_in = dp_status.shift_more ? S_SHIFT : S_RESPOND;
               default:   state_in = S_RESPOND;
            endcase
         end
         S_SHIFT:     state_in = S_EXEC;
         S_READ_WAIT: state_in = S_RESPOND;
         S_RESPOND: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_EXEC: begin
            unique case (dp_status.kind)
               OP_READ: cmd.mem_read = 1'b1;
               OP_INSERT: begin
                  if (dp_status.shift_more) begin
                     cmd.mem_read = 1'b1;
                  end else begin
                     cmd.place_write = 1'b1;
                     cmd.len_inc     = 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (dp_status.shift_more) begin
                     cmd.mem_read = 1'b1;
                  end else begin
                     cmd.len_dec = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_SHIFT:     cmd.shift_write  = 1'b1;
         S_READ_WAIT: cmd.capture_read = 1'b1;
         S_RESPOND:   rsp_valid        = 1'b1;
         default: ;
      endcase
   end

endmodule

FILE: rtl/ils_dpath.sv
// Datapath of the indexed list store: decode, cursor, length, entry RAM, response.
module ils_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  ils_pkg::ctrl_cmd_type       cmd,
   output ils_pkg::dp_status_type      dp_status,
   input  logic [2:0]                  req_action,
   input  logic [ils_pkg::LEN_W-1:0]   req_position,
   input  logic signed [31:0]          req_value,
   output logic signed [31:0]          rsp_read_value,
   output logic [1:0]                  rsp_status,
   output logic [ils_pkg::LEN_W-1:0]   rsp_list_length
);
   import ils_pkg::*;

   logic [LEN_W-1:0]    length_ff;
   logic [LEN_W-1:0]    cursor_ff;
   logic [LEN_W-1:0]    target_ff;
   op_kind_type         kind_ff;
   logic signed [31:0]  value_ff;
   logic signed [31:0]  rd_ff;
   status_type          status_ff;

   op_kind_type         dec_kind;
   status_type          dec_status;
   logic signed [31:0]  dec_rd;
   logic [LEN_W-1:0]    dec_target;
   logic [LEN_W-1:0]    dec_cursor;
   logic [LEN_W-1:0]    ins_place;

   logic [LEN_W-1:0]    cursor_dec;
   logic [LEN_W-1:0]    cursor_inc;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [DATA_W-1:0]   rd_data;

   // Check an incoming beat against the current length.
   always_comb begin
      dec_kind   = OP_NONE;
      dec_status = STAT_RANGE;
      dec_rd     = '0;
      dec_target = req_position;
      dec_cursor = req_position;
      ins_place  = req_position;
      unique case (action_type'(req_action)) inside
         ACT_READ: begin
            if (req_position < length_ff) begin
               dec_kind   = OP_READ;
               dec_status = STAT_DONE;
            end else begin
               dec_rd = -32'sd1;
            end
         end
         ACT_INS_HEAD, ACT_APPEND, ACT_INS_POS: begin
            if (action_type'(req_action) == ACT_INS_HEAD) begin
               ins_place = '0;
            end else if (action_type'(req_action) == ACT_APPEND) begin
               ins_place = length_ff;
            end
            dec_target = ins_place;
            dec_cursor = length_ff;
            if (ins_place > length_ff) begin
               dec_status = STAT_RANGE;
            end else if (length_ff >= LEN_W'(CAPACITY)) begin
               dec_status = STAT_FULL;
            end else begin
               dec_kind   = OP_INSERT;
               dec_status = STAT_DONE;
            end
         end
         ACT_DELETE: begin
            if (req_position < length_ff) begin
               dec_kind   = OP_DELETE;
               dec_status = STAT_DONE;
            end
         end
         default: ;
      endcase
   end

   // Latch the decoded beat and keep the response fields.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= dec_kind;
         status_ff <= dec_status;
         rd_ff     <= dec_rd;
         target_ff <= dec_target;
         value_ff  <= req_value;
      end else if (cmd.capture_read) begin
         rd_ff <= $signed(rd_data);
      end
   end

   assign cursor_dec = cursor_ff - LEN_W'(1);
   assign cursor_inc = cursor_ff + LEN_W'(1);

   // Shift cursor: walks down on an insert and up on a delete.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cursor_ff <= dec_cursor;
      end else if (cmd.shift_write) begin
         cursor_ff <= (kind_ff == OP_INSERT) ? cursor_dec : cursor_inc;
      end
   end

   // Length count.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (cmd.len_inc) begin
         length_ff <= length_ff + LEN_W'(1);
      end else if (cmd.len_dec) begin
         length_ff <= length_ff - LEN_W'(1);
      end
   end

   // Whether another entry still has to move.
   always_comb begin
      dp_status.kind = kind_ff;
      if (kind_ff == OP_INSERT) begin
         dp_status.shift_more = cursor_ff > target_ff;
      end else begin
         dp_status.shift_more = cursor_inc < length_ff;
      end
   end

   // RAM addressing: a shift reads the neighbour and writes it at the cursor.
   always_comb begin
      case (kind_ff)
         OP_INSERT: rd_addr = cursor_dec[ADDR_W-1:0];
         OP_DELETE: rd_addr = cursor_inc[ADDR_W-1:0];
         default:   rd_addr = target_ff[ADDR_W-1:0];
      endcase
      wr_addr = cmd.shift_write ? cursor_ff[ADDR_W-1:0] : target_ff[ADDR_W-1:0];
      wr_data = cmd.shift_write ? rd_data : DATA_W'(value_ff);
   end

   ils_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.shift_write | cmd.place_write),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_read_value  = rd_ff;
   assign rsp_status      = status_ff;
   assign rsp_list_length = length_ff;

endmodule

FILE: rtl/indexed_list_store.sv
// Top level of the indexed list store.
//
// The store holds an ordered list of up to 64 signed 32-bit values in one
// RAM. A request beat on req_ch carries an action (read, insert at head,
// append, insert before a position, delete) with a position and a value.
// Each request gives exactly one response beat on rsp_ch with the value
// read, a status (done, out of range, full) and the length afterwards.
// Requests are handled one at a time: req_ch.ready is high only while the
// block is idle. An action that moves no entry or is rejected goes from
// execute straight to the response; a read first waits for the registered
// RAM read. An insert or a delete moves the n entries behind the position
// (up to 63) one by one, each move being one RAM read followed by one RAM
// write on the shared port pair.
// The response is held in registers until rsp_ch.ready is high; the next
// request is taken in the cycle after that beat. Reset empties the list at
// once (the length goes to zero); no clearing pass runs over the RAM.
module indexed_list_store (
   input  logic  clock,
   input  logic  reset,
   ils_req_if.sink   req_ch,
   ils_rsp_if.source rsp_ch
);
   import ils_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Sequencer.
   ils_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Storage and response registers.
   ils_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .req_action      (req_ch.action),
      .req_position    (req_ch.position),
      .req_value       (req_ch.value),
      .rsp_read_value  (rsp_ch.read_value),
      .rsp_status      (rsp_ch.status),
      .rsp_list_length (rsp_ch.list_length)
   );

endmodule
